/* src/lam_pkg.sv */
package lam_pkg;

   localparam int unsigned MAX_VERTICES_DEF = 16;

   localparam int unsigned OP_W    = 3;
   localparam int unsigned VTX_W   = 4;
   localparam int unsigned LABEL_W = 32;
   localparam int unsigned CFG_W   = 5;
   localparam int unsigned COUNT_W = 9;

   localparam logic [CFG_W-1:0] VERTICES_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_SET      = 3'd0,
      OP_GET      = 3'd1,
      OP_REMOVE   = 3'd2,
      OP_LIST_OUT = 3'd3,
      OP_LIST_IN  = 3'd4,
      OP_LIST_ADJ = 3'd5
   } op_type;

   typedef struct packed {
      logic capture;
      logic point;
      logic start_in;
      logic start_out;
      logic step;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic list_ok;
      logic list_in;
      logic list_out;
      logic out_free;
      logic scan_stall;
      logic scan_end;
   } status_type;

endpackage

/* src/lam_req_if.sv */
interface lam_req_if;
   logic                                valid;
   logic                                ready;
   logic        [lam_pkg::OP_W-1:0]     operation;
   logic        [lam_pkg::VTX_W-1:0]    first_vertex;
   logic        [lam_pkg::VTX_W-1:0]    second_vertex;
   logic signed [lam_pkg::LABEL_W-1:0]  label_in;

   modport source (
      output valid, operation, first_vertex, second_vertex, label_in,
      input  ready
   );

   modport sink (
      input  valid, operation, first_vertex, second_vertex, label_in,
      output ready
   );
endinterface

/* src/lam_rsp_if.sv */
interface lam_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                in_range;
   logic                                found;
   logic signed [lam_pkg::LABEL_W-1:0]  label_out;
   logic        [lam_pkg::VTX_W-1:0]    neighbour;
   logic        [lam_pkg::COUNT_W-1:0]  edge_total;
   logic                                last;

   modport source (
      output valid, in_range, found, label_out, neighbour, edge_total, last,
      input  ready
   );

   modport sink (
      input  valid, in_range, found, label_out, neighbour, edge_total, last,
      output ready
   );
endinterface

/* src/labelled_adjacency_matrix.sv */
// channel   dir   handshake     payload
// req_bus   in    valid/ready   operation, first_vertex, second_vertex, label_in
// rsp_bus   out   valid/ready   in_range, found, label_out, neighbour, edge_total, last
// csr       in    csr_we        csr_wdata (vertices_in_use)
//
// Set, get, remove and rejected operations: the accept cycle reads the label memory;
// once the result register is free, ST_DECODE updates the store and loads the result.
// Lists scan the active vertices (in-edges, then out-edges for adjacent); the scan
// index tests one valid bit per cycle unless stalled and holds one found neighbour back.
// Reset clears every edge valid bit and the edge count, and sets vertices_in_use to 16.
// A stalled rsp_bus holds one result; the scan halts only on a second hit behind it.
module labelled_adjacency_matrix #(
   parameter int unsigned MAX_VERTICES = lam_pkg::MAX_VERTICES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   lam_req_if.sink                          req_bus,
   lam_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [lam_pkg::CFG_W-1:0]        csr_wdata
);

   lam_pkg::cmd_type    cmd;
   lam_pkg::status_type status;

   lam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lam_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_bus.operation),
      .req_first_vertex  (req_bus.first_vertex),
      .req_second_vertex (req_bus.second_vertex),
      .req_label_in      (req_bus.label_in),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .status            (status),
      .rsp_bus           (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   a_ready_drops: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request taken while previous transfer still in progress");

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.point, cmd.start_in, cmd.step, cmd.flush}))
      else $error("conflicting datapath commands");

   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.found |-> rsp_bus.last)
      else $error("result without a hit is not the final one");

   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.in_range |->
         !rsp_bus.found && rsp_bus.label_out == '0 && rsp_bus.neighbour == '0)
      else $error("rejected operation carries data");
`endif

endmodule

/* src/lam_ctrl.sv */
module lam_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lam_pkg::status_type status,
   output lam_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DECODE   = 5'b00010,
      ST_SCAN_IN  = 5'b00100,
      ST_SCAN_OUT = 5'b01000,
      ST_FLUSH    = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.list_ok) begin
               if (status.list_in) begin
                  cmd.start_in = 1'b1;
                  state_in     = ST_SCAN_IN;
               end else begin
                  cmd.start_out = 1'b1;
                  state_in      = ST_SCAN_OUT;
               end
            end else if (status.out_free) begin
               cmd.point = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_SCAN_IN: begin
            if (!status.scan_stall) begin
               cmd.step = 1'b1;
               if (status.scan_end) begin
                  if (status.list_out) begin
                     cmd.start_out = 1'b1;
                     state_in      = ST_SCAN_OUT;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_SCAN_OUT: begin
            if (!status.scan_stall) begin
               cmd.step = 1'b1;
               if (status.scan_end) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/lam_dpath.sv */
module lam_dpath #(
   parameter int unsigned MAX_VERTICES = lam_pkg::MAX_VERTICES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic        [lam_pkg::OP_W-1:0]    req_operation,
   input  logic        [lam_pkg::VTX_W-1:0]   req_first_vertex,
   input  logic        [lam_pkg::VTX_W-1:0]   req_second_vertex,
   input  logic signed [lam_pkg::LABEL_W-1:0] req_label_in,
   input  logic                               csr_we,
   input  logic        [lam_pkg::CFG_W-1:0]   csr_wdata,
   input  lam_pkg::cmd_type                   cmd,
   output lam_pkg::status_type                status,
   lam_rsp_if.source                          rsp_bus
);

   localparam int unsigned IW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int unsigned AW   = 2 * IW;
   localparam int unsigned LD   = 1 << AW;
   localparam int unsigned LIMW = lam_pkg::CFG_W + 1;
   localparam logic [LIMW-1:0]             MAX_WIDE = LIMW'(MAX_VERTICES);
   localparam logic [lam_pkg::CFG_W-1:0]   MAX_LIM  = lam_pkg::CFG_W'(MAX_VERTICES);

   logic [lam_pkg::CFG_W-1:0]   vertices_ff;
   lam_pkg::op_type             op_ff;
   logic [lam_pkg::VTX_W-1:0]   a_ff;
   logic [lam_pkg::VTX_W-1:0]   b_ff;
   logic [lam_pkg::LABEL_W-1:0] label_ff;
   logic [MAX_VERTICES-1:0]     valid_ff [MAX_VERTICES];
   logic [lam_pkg::COUNT_W-1:0] count_ff;
   logic [lam_pkg::COUNT_W-1:0] count_in;
   logic [IW-1:0]               idx_ff;
   logic                        dir_in_ff;
   logic                        pend_valid_ff;
   logic [IW-1:0]               pend_nb_ff;
   logic [lam_pkg::LABEL_W-1:0] label_mem [LD];
   logic [lam_pkg::LABEL_W-1:0] label_rd_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_in_range_ff;
   logic                        rsp_found_ff;
   logic [lam_pkg::LABEL_W-1:0] rsp_label_ff;
   logic [lam_pkg::VTX_W-1:0]   rsp_nb_ff;
   logic [lam_pkg::COUNT_W-1:0] rsp_total_ff;
   logic                        rsp_last_ff;

   logic [lam_pkg::CFG_W-1:0]   lim;
   logic                        a_ok;
   logic                        b_ok;
   logic [IW-1:0]               a_i;
   logic [IW-1:0]               b_i;
   logic                        cell_valid;
   logic                        is_point;
   logic                        is_list;
   logic                        point_ok;
   logic                        hit;
   logic                        out_free;
   logic                        do_set;
   logic                        do_rem;

   logic                        load;
   logic                        o_rng;
   logic                        o_fnd;
   logic [lam_pkg::LABEL_W-1:0] o_lab;
   logic [lam_pkg::VTX_W-1:0]   o_nb;
   logic                        o_last;

   assign lim  = ({1'b0, vertices_ff} > MAX_WIDE) ? MAX_LIM : vertices_ff;
   assign a_ok = lam_pkg::CFG_W'(a_ff) < lim;
   assign b_ok = lam_pkg::CFG_W'(b_ff) < lim;
   assign a_i  = IW'(a_ff);
   assign b_i  = IW'(b_ff);
   assign cell_valid = valid_ff[a_i][b_i];

   always_comb begin
      is_point = op_ff inside {lam_pkg::OP_SET, lam_pkg::OP_GET, lam_pkg::OP_REMOVE};
      is_list  = op_ff inside {lam_pkg::OP_LIST_OUT, lam_pkg::OP_LIST_IN,
                               lam_pkg::OP_LIST_ADJ};
   end

   assign status.list_in  = op_ff inside {lam_pkg::OP_LIST_IN, lam_pkg::OP_LIST_ADJ};
   assign status.list_out = op_ff inside {lam_pkg::OP_LIST_OUT, lam_pkg::OP_LIST_ADJ};

   assign point_ok = is_point && a_ok && b_ok;
   assign hit      = dir_in_ff ? valid_ff[idx_ff][a_i] : valid_ff[a_i][idx_ff];
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign status.list_ok    = is_list && a_ok;
   assign status.out_free   = out_free;
   assign status.scan_stall = hit && pend_valid_ff && !out_free;
   assign status.scan_end   = dir_in_ff ? (idx_ff == '0)
                                        : (lam_pkg::CFG_W'(idx_ff) == lim - 5'd1);

   assign do_set = cmd.point && point_ok && (op_ff == lam_pkg::OP_SET);
   assign do_rem = cmd.point && point_ok && (op_ff == lam_pkg::OP_REMOVE) && cell_valid;

   always_comb begin
      count_in = count_ff;
      if (do_set && !cell_valid) begin
         count_in = count_ff + lam_pkg::COUNT_W'(1);
      end else if (do_rem) begin
         count_in = count_ff - lam_pkg::COUNT_W'(1);
      end
   end

   always_comb begin
      load   = 1'b0;
      o_rng  = 1'b0;
      o_fnd  = 1'b0;
      o_lab  = '0;
      o_nb   = '0;
      o_last = 1'b1;
      if (cmd.point) begin
         load = 1'b1;
         if (point_ok) begin
            o_rng = 1'b1;
            case (op_ff)
               lam_pkg::OP_SET: begin
                  o_fnd = 1'b1;
               end
               lam_pkg::OP_GET: begin
                  o_fnd = cell_valid;
                  if (cell_valid) begin
                     o_lab = label_rd_ff;
                  end
               end
               lam_pkg::OP_REMOVE: begin
                  o_fnd = cell_valid;
               end
               default: begin
                  o_fnd = 1'b0;
               end
            endcase
         end
      end else if (cmd.step && hit && pend_valid_ff) begin
         load   = 1'b1;
         o_rng  = 1'b1;
         o_fnd  = 1'b1;
         o_nb   = lam_pkg::VTX_W'(pend_nb_ff);
         o_last = 1'b0;
      end else if (cmd.flush) begin
         load  = 1'b1;
         o_rng = 1'b1;
         o_fnd = pend_valid_ff;
         if (pend_valid_ff) begin
            o_nb = lam_pkg::VTX_W'(pend_nb_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertices_ff   <= lam_pkg::VERTICES_RESET;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '{default: '0};
      end else begin
         if (csr_we) begin
            vertices_ff <= csr_wdata;
         end
         count_ff <= count_in;
         if (do_set) begin
            valid_ff[a_i][b_i] <= 1'b1;
         end else if (do_rem) begin
            valid_ff[a_i][b_i] <= 1'b0;
         end
         if (cmd.capture) begin
            pend_valid_ff <= 1'b0;
         end else if (cmd.step && hit) begin
            pend_valid_ff <= 1'b1;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_set) begin
         label_mem[{a_i, b_i}] <= label_ff;
      end
      if (cmd.capture) begin
         label_rd_ff <= label_mem[{IW'(req_first_vertex), IW'(req_second_vertex)}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= lam_pkg::op_type'(req_operation);
         a_ff     <= req_first_vertex;
         b_ff     <= req_second_vertex;
         label_ff <= req_label_in;
      end
      if (cmd.start_in) begin
         idx_ff    <= IW'(lim - 5'd1);
         dir_in_ff <= 1'b1;
      end else if (cmd.start_out) begin
         idx_ff    <= '0;
         dir_in_ff <= 1'b0;
      end else if (cmd.step) begin
         idx_ff <= dir_in_ff ? idx_ff - IW'(1) : idx_ff + IW'(1);
      end
      if (cmd.step && hit) begin
         pend_nb_ff <= idx_ff;
      end
      if (load) begin
         rsp_in_range_ff <= o_rng;
         rsp_found_ff    <= o_fnd;
         rsp_label_ff    <= o_lab;
         rsp_nb_ff       <= o_nb;
         rsp_total_ff    <= count_in;
         rsp_last_ff     <= o_last;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.in_range   = rsp_in_range_ff;
   assign rsp_bus.found      = rsp_found_ff;
   assign rsp_bus.label_out  = rsp_label_ff;
   assign rsp_bus.neighbour  = rsp_nb_ff;
   assign rsp_bus.edge_total = rsp_total_ff;
   assign rsp_bus.last       = rsp_last_ff;

endmodule
